/* rtl/cppi_pkg.sv */
// Package for the closed-path pose interpolator.
// Holds sizes, the shared arithmetic unit's opcodes and its request/response structs.
// Depends on nothing.
package cppi_pkg;

    localparam int MAX_POINTS = 8;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // segment length: floor(sqrt(3 * 2^64)) < 2^33
    localparam int LEN_W      = 33;
    localparam int TOT_W      = LEN_W + $clog2(MAX_POINTS);
    localparam int PT_W       = 96;

    // shared unit operand and result sizes
    localparam int M_W        = 34;             // multiplier operand
    localparam int A_W        = 2 * LEN_W;      // radicand / dividend bus
    localparam int B_W        = M_W;
    localparam int R_W        = 2 * M_W;
    localparam int DN_W       = LEN_W + 16;     // dividend below den * 2^17
    localparam int RR_W       = LEN_W + 4;      // square root remainder
    localparam int DIV_STEPS  = 17;
    localparam int ROOT_STEPS = A_W / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_alu_op;

    typedef struct packed {
        logic           start;
        t_alu_op        op;
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic           done;
        logic [R_W-1:0] res;
    } t_alu_rsp;

endpackage

/* rtl/closed_path_pose_interpolator.sv */
// Closed-path pose interpolator, top level.
// Uses cppi_pkg, cppi_ram (point and length stores) and cppi_alu (shared unit).
//
// A load (command 0) writes one Q16.16 point into its slot and gives no
// result. A query (command 1) keeps busy high through these steps: per
// segment two point reads, three squares and a square root, then the target
// from two multiplies, the scan over stored lengths, one divide for the local
// fraction, three multiplies for the position, the heading root, five divides
// for the basis and four multiplies for up; a zero heading skips those last two.
// A query's length is set mostly by the bit-serial roots and divides on the one shared unit.
// The four columns (right, up, back, position) then leave back to back,
// each for one cycle under o_result_strobe; the receiver cannot stall
// them, so it must take every transfer as it comes. busy drops on the cycle
// the last column shows, and a new item may be started from then on.
// Point slots that were never loaded read as garbage; point_count is clamped
// to 2..MAX_POINTS at query time.
module closed_path_pose_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [2:0]  i_point_index,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic [15:0] i_progress,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    output logic        o_result_strobe,
    output logic [1:0]  o_column_index,
    output logic [31:0] o_comp_x,
    output logic [31:0] o_comp_y,
    output logic [31:0] o_comp_z,
    output logic        o_last_column,
    output logic        o_degenerate
);
    import cppi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WAIT,
        S_LRD0, S_LRD1, S_LRD2, S_LSQ, S_LSQA, S_LRT, S_LEN,
        S_TM, S_TMA,
        S_SRD0, S_SRD1,
        S_PRD0, S_PRD1, S_PRD2, S_LTD, S_LTA, S_PM, S_PMA,
        S_HM, S_HMA, S_HRT, S_HA,
        S_FD, S_FA, S_UM, S_UA,
        S_OUT
    } t_state;

    localparam int FT_W = TOT_W + 16;

    t_state                  r_state;
    t_state                  r_ret;
    logic [3:0]              r_point_count;
    logic [CNT_W-1:0]        r_n;
    logic [IDX_W-1:0]        r_i;
    logic [2:0]              r_k;
    logic [15:0]             r_prog;
    logic [PT_W-1:0]         r_pa;
    logic [PT_W-1:0]         r_pb;
    logic [A_W-1:0]          r_acc;
    logic [TOT_W-1:0]        r_total;
    logic [TOT_W-1:0]        r_target;
    logic [TOT_W-1:0]        r_curr;
    logic [LEN_W-1:0]        r_seg;
    logic [LEN_W-1:0]        r_h;
    logic [15:0]             r_lt;
    logic [31:0]             r_px, r_py, r_pz;
    logic signed [17:0]      r_fx, r_fy, r_fz, r_rx, r_rz;
    logic signed [18:0]      r_ux, r_uy, r_uz;
    logic [33:0]             r_tmp;
    logic                    r_degen;

    t_alu_req                w_req;
    t_alu_rsp                w_rsp;

    logic [CNT_W-1:0]        w_n;
    logic                    w_last;
    logic [IDX_W-1:0]        w_j;
    logic                    w_pt_we;
    logic [IDX_W-1:0]        w_pt_raddr;
    logic [PT_W-1:0]         w_pt_rdata;
    logic [LEN_W-1:0]        w_len_rdata;
    logic                    w_len_we;

    logic signed [32:0]      w_dx, w_dy, w_dz, w_ex, w_ey, w_ez;
    logic signed [32:0]      w_dk, w_ek, w_hk, w_fnum;
    logic [31:0]             w_pak;
    logic [LEN_W-1:0]        w_fden;
    logic signed [17:0]      w_ua, w_ub;
    logic                    w_uneg;
    logic signed [33:0]      w_sp;
    logic [32:0]             w_sh;
    logic [33:0]             w_pos;
    logic [16:0]             w_q;
    logic signed [17:0]      w_fq;
    logic [FT_W-1:0]         w_full;
    logic [TOT_W:0]          w_run;
    logic [LEN_W-1:0]        w_num;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [16:0] mag18(input logic signed [17:0] v);
        logic [17:0] m;
        m     = v[17] ? 18'(-v) : 18'(v);
        mag18 = m[16:0];
    endfunction

    // truncating divide by 2^16
    function automatic logic signed [18:0] tdiv16(input logic signed [34:0] v);
        logic [34:0] m;
        logic [18:0] s;
        m      = v[34] ? 35'(-v) : 35'(v);
        s      = m[34:16];
        tdiv16 = v[34] ? 19'(-s) : s;
    endfunction

    // ---------------- stores and shared unit ----------------
    assign w_pt_we = start && !busy && !i_command && (int'(i_point_index) < MAX_POINTS);

    cppi_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_points (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (IDX_W'(i_point_index)),
        .i_wdata ({i_point_x, i_point_y, i_point_z}),
        .i_raddr (w_pt_raddr),
        .o_rdata (w_pt_rdata)
    );

    assign w_len_we = (r_state == S_LEN);

    cppi_ram #(.WIDTH(LEN_W), .DEPTH(MAX_POINTS)) u_lens (
        .i_clk   (i_clk),
        .i_we    (w_len_we),
        .i_waddr (r_i),
        .i_wdata (w_rsp.res[LEN_W-1:0]),
        .i_raddr (r_i),
        .o_rdata (w_len_rdata)
    );

    cppi_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ---------------- index helpers ----------------
    always_comb begin
        if (int'(r_point_count) < 2) begin
            w_n = CNT_W'(2);
        end else if (int'(r_point_count) > MAX_POINTS) begin
            w_n = CNT_W'(MAX_POINTS);
        end else begin
            w_n = CNT_W'(r_point_count);
        end
    end

    assign w_last = (CNT_W'(r_i) + CNT_W'(1)) == r_n;
    assign w_j    = w_last ? '0 : r_i + 1'b1;
    assign w_pt_raddr = (r_state == S_LRD1 || r_state == S_PRD1) ? w_j : r_i;

    // ---------------- datapath selects ----------------
    // d = p_i - p_j (lengths and basis), e = p_j - p_i (position and right z)
    assign w_dx = {r_pa[95], r_pa[95:64]} - {r_pb[95], r_pb[95:64]};
    assign w_dy = {r_pa[63], r_pa[63:32]} - {r_pb[63], r_pb[63:32]};
    assign w_dz = {r_pa[31], r_pa[31:0]}  - {r_pb[31], r_pb[31:0]};
    assign w_ex = {r_pb[95], r_pb[95:64]} - {r_pa[95], r_pa[95:64]};
    assign w_ey = {r_pb[63], r_pb[63:32]} - {r_pa[63], r_pa[63:32]};
    assign w_ez = {r_pb[31], r_pb[31:0]}  - {r_pa[31], r_pa[31:0]};

    always_comb begin
        case (r_k)
            3'd0: begin
                w_dk = w_dx; w_ek = w_ex; w_pak = r_pa[95:64];
                w_hk = w_dx; w_fnum = w_dx; w_fden = r_seg;
                w_ua = r_fy; w_ub = r_rz;
            end
            3'd1: begin
                w_dk = w_dy; w_ek = w_ey; w_pak = r_pa[63:32];
                w_hk = w_dz; w_fnum = w_dy; w_fden = r_seg;
                w_ua = r_fz; w_ub = r_rx;
            end
            3'd2: begin
                w_dk = w_dz; w_ek = w_ez; w_pak = r_pa[31:0];
                w_hk = w_dz; w_fnum = w_dz; w_fden = r_seg;
                w_ua = r_fx; w_ub = r_rz;
            end
            3'd3: begin
                w_dk = w_dz; w_ek = w_ez; w_pak = r_pa[31:0];
                w_hk = w_dz; w_fnum = w_dz; w_fden = r_h;
                w_ua = r_fy; w_ub = r_rx;
            end
            default: begin
                // right z takes -dx
                w_dk = w_dx; w_ek = w_ex; w_pak = r_pa[95:64];
                w_hk = w_dx; w_fnum = w_ex; w_fden = r_h;
                w_ua = r_fy; w_ub = r_rx;
            end
        endcase
    end

    assign w_uneg = w_ua[17] ^ w_ub[17];
    assign w_sp   = w_uneg ? -signed'({1'b0, w_rsp.res[32:0]})
                           :  signed'({1'b0, w_rsp.res[32:0]});
    assign w_sh   = w_rsp.res[48:16];
    assign w_pos  = {w_pak[31], w_pak[31], w_pak}
                  + (w_ek[32] ? 34'(-{1'b0, w_sh}) : {1'b0, w_sh});
    assign w_q    = w_rsp.res[16:0];
    assign w_fq   = w_fnum[32] ? 18'(-{1'b0, w_q}) : {1'b0, w_q};
    assign w_full = FT_W'(r_acc) + (FT_W'(w_rsp.res) << M_W);
    assign w_run  = (TOT_W+1)'(r_curr) + (TOT_W+1)'(w_len_rdata);
    assign w_num  = LEN_W'(r_target - r_curr);

    // ---------------- shared unit requests ----------------
    always_comb begin
        w_req       = '0;
        w_req.op    = OP_MUL;
        case (r_state)
            S_LSQ: begin
                w_req.start = 1'b1;
                w_req.a     = A_W'(mag33(w_dk));
                w_req.b     = B_W'(mag33(w_dk));
            end
            S_HM: begin
                w_req.start = 1'b1;
                w_req.a     = A_W'(mag33(w_hk));
                w_req.b     = B_W'(mag33(w_hk));
            end
            S_LRT, S_HRT: begin
                w_req.start = 1'b1;
                w_req.op    = OP_SQRT;
                w_req.a     = r_acc;
            end
            S_TM: begin
                w_req.start = 1'b1;
                w_req.a     = A_W'(r_prog);
                w_req.b     = (r_k == 3'd0) ? M_W'(r_total) : M_W'(r_total >> M_W);
            end
            S_LTD: begin
                w_req.start = (r_seg != '0);
                w_req.op    = OP_DIV;
                w_req.a     = A_W'({w_num, 16'b0});
                w_req.b     = B_W'(r_seg);
            end
            S_PM: begin
                w_req.start = 1'b1;
                w_req.a     = A_W'(mag33(w_ek));
                w_req.b     = B_W'(r_lt);
            end
            S_FD: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_req.a     = A_W'({mag33(w_fnum), 16'b0});
                w_req.b     = B_W'(w_fden);
            end
            S_UM: begin
                w_req.start = 1'b1;
                w_req.a     = A_W'(mag18(w_ua));
                w_req.b     = B_W'(mag18(w_ub));
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_point_count   <= 4'd8;
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (start && i_command) begin
                        r_prog  <= i_progress;
                        r_n     <= w_n;
                        r_i     <= '0;
                        r_total <= '0;
                        r_state <= S_LRD0;
                    end
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_state <= r_ret;
                    end
                end
                // segment lengths
                S_LRD0: r_state <= S_LRD1;
                S_LRD1: begin
                    r_pa    <= w_pt_rdata;
                    r_state <= S_LRD2;
                end
                S_LRD2: begin
                    r_pb    <= w_pt_rdata;
                    r_acc   <= '0;
                    r_k     <= '0;
                    r_state <= S_LSQ;
                end
                S_LSQ: begin
                    r_ret   <= S_LSQA;
                    r_state <= S_WAIT;
                end
                S_LSQA: begin
                    r_acc <= r_acc + A_W'(w_rsp.res);
                    if (r_k == 3'd2) begin
                        r_state <= S_LRT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LSQ;
                    end
                end
                S_LRT: begin
                    r_ret   <= S_LEN;
                    r_state <= S_WAIT;
                end
                S_LEN: begin
                    r_total <= r_total + TOT_W'(w_rsp.res[LEN_W-1:0]);
                    if (w_last) begin
                        r_k     <= '0;
                        r_state <= S_TM;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_LRD0;
                    end
                end
                // target = progress * total / 2^16, in two partial products
                S_TM: begin
                    r_ret   <= S_TMA;
                    r_state <= S_WAIT;
                end
                S_TMA: begin
                    if (r_k == 3'd0) begin
                        r_acc   <= A_W'(w_rsp.res);
                        r_k     <= 3'd1;
                        r_state <= S_TM;
                    end else begin
                        r_target <= TOT_W'(w_full >> 16);
                        r_curr   <= '0;
                        r_i      <= '0;
                        r_state  <= S_SRD0;
                    end
                end
                // scan for the segment holding the target
                S_SRD0: r_state <= S_SRD1;
                S_SRD1: begin
                    if (w_run > (TOT_W+1)'(r_target)) begin
                        r_seg   <= w_len_rdata;
                        r_state <= S_PRD0;
                    end else if (w_last) begin
                        // zero-length path: segment 0, fraction 0
                        r_i     <= '0;
                        r_curr  <= '0;
                        r_seg   <= '0;
                        r_state <= S_PRD0;
                    end else begin
                        r_curr  <= w_run[TOT_W-1:0];
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRD0;
                    end
                end
                S_PRD0: r_state <= S_PRD1;
                S_PRD1: begin
                    r_pa    <= w_pt_rdata;
                    r_state <= S_PRD2;
                end
                S_PRD2: begin
                    r_pb    <= w_pt_rdata;
                    r_state <= S_LTD;
                end
                S_LTD: begin
                    r_k <= '0;
                    if (r_seg == '0) begin
                        r_lt    <= '0;
                        r_state <= S_PM;
                    end else begin
                        r_ret   <= S_LTA;
                        r_state <= S_WAIT;
                    end
                end
                S_LTA: begin
                    r_lt    <= w_rsp.res[15:0];
                    r_state <= S_PM;
                end
                // position
                S_PM: begin
                    r_ret   <= S_PMA;
                    r_state <= S_WAIT;
                end
                S_PMA: begin
                    case (r_k)
                        3'd0:    r_px <= w_pos[31:0];
                        3'd1:    r_py <= w_pos[31:0];
                        default: r_pz <= w_pos[31:0];
                    endcase
                    if (r_k == 3'd2) begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_HM;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PM;
                    end
                end
                // horizontal length of the heading
                S_HM: begin
                    r_ret   <= S_HMA;
                    r_state <= S_WAIT;
                end
                S_HMA: begin
                    r_acc <= r_acc + A_W'(w_rsp.res);
                    if (r_k == 3'd1) begin
                        r_state <= S_HRT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_HM;
                    end
                end
                S_HRT: begin
                    r_ret   <= S_HA;
                    r_state <= S_WAIT;
                end
                S_HA: begin
                    r_h <= w_rsp.res[LEN_W-1:0];
                    r_k <= '0;
                    if (w_rsp.res[LEN_W-1:0] == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_degen <= 1'b0;
                        r_state <= S_FD;
                    end
                end
                // forward and right vectors
                S_FD: begin
                    r_ret   <= S_FA;
                    r_state <= S_WAIT;
                end
                S_FA: begin
                    case (r_k)
                        3'd0:    r_fx <= w_fq;
                        3'd1:    r_fy <= w_fq;
                        3'd2:    r_fz <= w_fq;
                        3'd3:    r_rx <= w_fq;
                        default: r_rz <= w_fq;
                    endcase
                    if (r_k == 3'd4) begin
                        r_k     <= '0;
                        r_state <= S_UM;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_FD;
                    end
                end
                // up = cross(f, right)
                S_UM: begin
                    r_ret   <= S_UA;
                    r_state <= S_WAIT;
                end
                S_UA: begin
                    case (r_k)
                        3'd0:    r_ux  <= tdiv16({w_sp[33], w_sp});
                        3'd1:    r_tmp <= w_sp;
                        3'd2:    r_uy  <= tdiv16({r_tmp[33], r_tmp} - {w_sp[33], w_sp});
                        default: r_uz  <= tdiv16(-{w_sp[33], w_sp});
                    endcase
                    if (r_k == 3'd3) begin
                        r_k     <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_UM;
                    end
                end
                // one column transfer per cycle
                S_OUT: begin
                    o_result_strobe <= 1'b1;
                    o_column_index  <= r_k[1:0];
                    o_last_column   <= (r_k == 3'd3);
                    o_degenerate    <= r_degen;
                    case (r_k)
                        3'd0: begin
                            o_comp_x <= r_degen ? ONE_Q16 : {{14{r_rx[17]}}, r_rx};
                            o_comp_y <= '0;
                            o_comp_z <= r_degen ? '0 : {{14{r_rz[17]}}, r_rz};
                        end
                        3'd1: begin
                            o_comp_x <= r_degen ? '0 : {{13{r_ux[18]}}, r_ux};
                            o_comp_y <= r_degen ? ONE_Q16 : {{13{r_uy[18]}}, r_uy};
                            o_comp_z <= r_degen ? '0 : {{13{r_uz[18]}}, r_uz};
                        end
                        3'd2: begin
                            o_comp_x <= r_degen ? '0 : 32'(-{{14{r_fx[17]}}, r_fx});
                            o_comp_y <= r_degen ? '0 : 32'(-{{14{r_fy[17]}}, r_fy});
                            o_comp_z <= r_degen ? ONE_Q16 : 32'(-{{14{r_fz[17]}}, r_fz});
                        end
                        default: begin
                            o_comp_x <= r_px;
                            o_comp_y <= r_py;
                            o_comp_z <= r_pz;
                        end
                    endcase
                    if (r_k == 3'd3) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/cppi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cppi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/cppi_alu.sv */
// Shared arithmetic unit: registered 34x34 multiply, bit-serial divide
// (17 quotient bits) and bit-serial integer square root. Uses cppi_pkg.
module cppi_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cppi_pkg::t_alu_req i_req,
    output cppi_pkg::t_alu_rsp o_rsp
);
    import cppi_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic [STEP_W-1:0] r_cnt;
    logic [A_W-1:0]    r_x;
    logic [DN_W-1:0]   r_y;
    logic [RR_W-1:0]   r_r;
    logic [R_W-1:0]    r_q;

    logic [RR_W-1:0]   w_rem2;
    logic [RR_W-1:0]   w_trial;

    assign w_rem2  = {r_r[RR_W-3:0], r_x[A_W-1 -: 2]};
    assign w_trial = RR_W'({r_q[LEN_W-1:0], 2'b01});

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op <= i_req.op;
                case (i_req.op)
                    OP_MUL: begin
                        r_q    <= R_W'(i_req.a[B_W-1:0]) * R_W'(i_req.b);
                        r_done <= 1'b1;
                    end
                    OP_DIV: begin
                        r_x    <= i_req.a;
                        r_y    <= DN_W'({i_req.b[LEN_W-1:0], 16'b0});
                        r_q    <= '0;
                        r_cnt  <= STEP_W'(DIV_STEPS - 1);
                        r_busy <= 1'b1;
                    end
                    OP_SQRT: begin
                        r_x    <= i_req.a;
                        r_r    <= '0;
                        r_q    <= '0;
                        r_cnt  <= STEP_W'(ROOT_STEPS - 1);
                        r_busy <= 1'b1;
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    OP_DIV: begin
                        if (r_x[DN_W-1:0] >= r_y) begin
                            r_x <= A_W'(r_x[DN_W-1:0] - r_y);
                            r_q <= {r_q[R_W-2:0], 1'b1};
                        end else begin
                            r_q <= {r_q[R_W-2:0], 1'b0};
                        end
                        r_y <= r_y >> 1;
                    end
                    default: begin
                        // one root bit per cycle, two radicand bits consumed
                        if (w_rem2 >= w_trial) begin
                            r_r <= w_rem2 - w_trial;
                            r_q <= {r_q[R_W-2:0], 1'b1};
                        end else begin
                            r_r <= w_rem2;
                            r_q <= {r_q[R_W-2:0], 1'b0};
                        end
                        r_x <= r_x << 2;
                    end
                endcase
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule
